>>> design/mcf_pkg.sv
// Shared types and constants for the reference row fetch generator.
`default_nettype none

package mcf_pkg;

  // Block geometry.
  localparam int LUMA_BLOCK    = 16;
  localparam int CHROMA_BLOCK  = 8;
  localparam int MAX_FRAME_DIM = 4096;

  // Field and register widths.
  localparam int DIM_W     = 13;
  localparam int STRIDE_W  = 14;
  localparam int CSTRIDE_W = 13;
  localparam int ADDR_W    = 25;
  localparam int POS_W     = 12;
  localparam int LEN_W     = 5;
  localparam int ROW_W     = 5;
  localparam int COORD_W   = 8;
  localparam int MV_W      = 11;
  localparam int RAW_W     = 14;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  typedef logic [1:0] plane_t;
  localparam plane_t PLANE_LUMA = 2'd0;
  localparam plane_t PLANE_U    = 2'd1;
  localparam plane_t PLANE_V    = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_FRAME_WIDTH   = 2'd0;
  localparam reg_idx_t REG_FRAME_HEIGHT  = 2'd1;
  localparam reg_idx_t REG_LUMA_STRIDE   = 2'd2;
  localparam reg_idx_t REG_CHROMA_STRIDE = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0]     frame_width;
    logic [DIM_W-1:0]     frame_height;
    logic [STRIDE_W-1:0]  luma_stride;
    logic [CSTRIDE_W-1:0] chroma_stride;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   load;
    logic   calc1;
    logic   calc2;
    logic   mult;
    logic   emit;
    plane_t plane;
    logic   last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic outside;
    logic chroma_ok;
    logic luma_row_last;
    logic chroma_row_last;
  } status_t;

endpackage

`default_nettype wire

>>> design/mcf_regs.sv
// Configuration register bank behind the APB-style port.
`default_nettype none

module mcf_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mcf_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [mcf_pkg::PDATA_W-1:0]   pwdata,
  output logic      [mcf_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output mcf_pkg::cfg_t                      cfg
);
  import mcf_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = paddr[PADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= DIM_W'(1920);
      cfg.frame_height  <= DIM_W'(1080);
      cfg.luma_stride   <= STRIDE_W'(1920);
      cfg.chroma_stride <= CSTRIDE_W'(960);
    end else if (wr) begin
      case (idx)
        REG_FRAME_WIDTH:   cfg.frame_width   <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:  cfg.frame_height  <= pwdata[DIM_W-1:0];
        REG_LUMA_STRIDE:   cfg.luma_stride   <= pwdata[STRIDE_W-1:0];
        REG_CHROMA_STRIDE: cfg.chroma_stride <= pwdata[CSTRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:   prdata = PDATA_W'(cfg.frame_width);
      REG_FRAME_HEIGHT:  prdata = PDATA_W'(cfg.frame_height);
      REG_LUMA_STRIDE:   prdata = PDATA_W'(cfg.luma_stride);
      REG_CHROMA_STRIDE: prdata = PDATA_W'(cfg.chroma_stride);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/mcf_ctrl.sv
// Sequencing state machine for one macroblock fetch request.
`default_nettype none

module mcf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire mcf_pkg::status_t st,
  output mcf_pkg::cmd_t         cmd
);
  import mcf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CALC1, S_CALC2, S_MULT, S_LUMA, S_CHROMA_U, S_CHROMA_V
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CALC1;
            busy  <= 1'b1;
          end
        end
        S_CALC1: state <= S_CALC2;
        S_CALC2: begin
          if (st.outside) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end else begin
            state <= S_MULT;
          end
        end
        S_MULT: state <= S_LUMA;
        S_LUMA: begin
          if (st.luma_row_last) begin
            if (st.chroma_ok) begin
              state <= S_CHROMA_U;
            end else begin
              state <= S_IDLE;
              busy  <= 1'b0;
            end
          end
        end
        S_CHROMA_U: state <= S_CHROMA_V;
        S_CHROMA_V: begin
          if (st.chroma_row_last) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end else begin
            state <= S_CHROMA_U;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.plane = PLANE_LUMA;
    case (state)
      S_IDLE:  cmd.load  = start;
      S_CALC1: cmd.calc1 = 1'b1;
      S_CALC2: cmd.calc2 = 1'b1;
      S_MULT:  cmd.mult  = 1'b1;
      S_LUMA: begin
        cmd.emit = 1'b1;
        cmd.last = st.luma_row_last && !st.chroma_ok;
      end
      S_CHROMA_U: begin
        cmd.emit  = 1'b1;
        cmd.plane = PLANE_U;
      end
      S_CHROMA_V: begin
        cmd.emit  = 1'b1;
        cmd.plane = PLANE_V;
        cmd.last  = st.chroma_row_last;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> design/mcf_datapath.sv
// Geometry, clamping, base address and row descriptor datapath.
`default_nettype none

module mcf_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire mcf_pkg::cfg_t                      cfg,
  input  wire mcf_pkg::cmd_t                      cmd,
  output mcf_pkg::status_t                        st,
  input  wire logic [mcf_pkg::COORD_W-1:0]        mb_col,
  input  wire logic [mcf_pkg::COORD_W-1:0]        mb_row,
  input  wire logic signed [mcf_pkg::MV_W-1:0]    mv_dx,
  input  wire logic signed [mcf_pkg::MV_W-1:0]    mv_dy,
  output logic                                    strobe,
  output logic [1:0]                              plane,
  output logic [mcf_pkg::ADDR_W-1:0]              src_address,
  output logic [mcf_pkg::LEN_W-1:0]               row_length,
  output logic [mcf_pkg::POS_W-1:0]               dest_x,
  output logic [mcf_pkg::POS_W-1:0]               dest_y,
  output logic                                    last
);
  import mcf_pkg::*;

  // Captured request.
  logic [COORD_W-1:0] col_q, row_q;
  logic [MV_W-1:0]    mvx_q, mvy_q;

  // First calculation stage.
  logic             outside, chroma_ok;
  logic [LEN_W-1:0] w_q, h_q, cw_q, ch_q;
  logic [RAW_W-1:0] rx_raw, ry_raw, cx_raw, cy_raw;

  // Clamped reference positions.
  logic [POS_W-1:0] rx, ry, cx, cy;

  logic [ADDR_W-1:0] luma_base, chroma_base, addr;
  logic [ROW_W-1:0]  row_cnt;

  logic [DIM_W-1:0]  fw, fh, cfw, cfh;
  logic [DIM_W-1:0]  px, py, cpx, cpy;
  logic [DIM_W-1:0]  lrem_x, lrem_y, crem_x, crem_y;
  logic [MV_W:0]     mvx_t, mvy_t;
  logic [MV_W-1:0]   mvx_h, mvy_h;

  function automatic logic [POS_W-1:0] clamp_pos(input logic [RAW_W-1:0] raw,
                                                 input logic [DIM_W-1:0] hi);
    logic [POS_W-1:0] r;
    if (raw[RAW_W-1]) begin
      r = '0;
    end else if (raw[DIM_W-1:0] > hi) begin
      r = hi[POS_W-1:0];
    end else begin
      r = raw[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] min_len(input logic [DIM_W-1:0] rem,
                                               input logic [DIM_W-1:0] blk);
    logic [LEN_W-1:0] r;
    if (rem >= blk) begin
      r = blk[LEN_W-1:0];
    end else begin
      r = rem[LEN_W-1:0];
    end
    return r;
  endfunction

  // Frame size saturated to the largest supported dimension.
  assign fw  = (cfg.frame_width  > DIM_W'(MAX_FRAME_DIM)) ? DIM_W'(MAX_FRAME_DIM)
                                                          : cfg.frame_width;
  assign fh  = (cfg.frame_height > DIM_W'(MAX_FRAME_DIM)) ? DIM_W'(MAX_FRAME_DIM)
                                                          : cfg.frame_height;
  assign cfw = fw >> 1;
  assign cfh = fh >> 1;

  assign px  = DIM_W'(DIM_W'(col_q) * DIM_W'(LUMA_BLOCK));
  assign py  = DIM_W'(DIM_W'(row_q) * DIM_W'(LUMA_BLOCK));
  assign cpx = DIM_W'(DIM_W'(col_q) * DIM_W'(CHROMA_BLOCK));
  assign cpy = DIM_W'(DIM_W'(row_q) * DIM_W'(CHROMA_BLOCK));

  assign lrem_x = fw  - px;
  assign lrem_y = fh  - py;
  assign crem_x = cfw - cpx;
  assign crem_y = cfh - cpy;

  // Halving that truncates toward zero: add one to negative values first.
  assign mvx_t = {mvx_q[MV_W-1], mvx_q} + {{MV_W{1'b0}}, mvx_q[MV_W-1]};
  assign mvy_t = {mvy_q[MV_W-1], mvy_q} + {{MV_W{1'b0}}, mvy_q[MV_W-1]};
  assign mvx_h = mvx_t[MV_W:1];
  assign mvy_h = mvy_t[MV_W:1];

  // Luma start address, formed from the clamped position.
  assign luma_base = ADDR_W'(ry * cfg.luma_stride) + ADDR_W'(rx);

  assign st.outside         = outside;
  assign st.chroma_ok       = chroma_ok;
  assign st.luma_row_last   = (row_cnt == h_q - LEN_W'(1));
  assign st.chroma_row_last = (row_cnt == ch_q - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_q <= mb_col;
      row_q <= mb_row;
      mvx_q <= mv_dx;
      mvy_q <= mv_dy;
    end
    if (cmd.calc1) begin
      outside   <= (px >= fw) || (py >= fh);
      chroma_ok <= (crem_x != '0) && (crem_y != '0);
      w_q       <= min_len(lrem_x, DIM_W'(LUMA_BLOCK));
      h_q       <= min_len(lrem_y, DIM_W'(LUMA_BLOCK));
      cw_q      <= min_len(crem_x, DIM_W'(CHROMA_BLOCK));
      ch_q      <= min_len(crem_y, DIM_W'(CHROMA_BLOCK));
      rx_raw    <= RAW_W'(px)  + {{(RAW_W-MV_W){mvx_q[MV_W-1]}}, mvx_q};
      ry_raw    <= RAW_W'(py)  + {{(RAW_W-MV_W){mvy_q[MV_W-1]}}, mvy_q};
      cx_raw    <= RAW_W'(cpx) + {{(RAW_W-MV_W){mvx_h[MV_W-1]}}, mvx_h};
      cy_raw    <= RAW_W'(cpy) + {{(RAW_W-MV_W){mvy_h[MV_W-1]}}, mvy_h};
    end
    if (cmd.calc2) begin
      rx <= clamp_pos(rx_raw, fw  - DIM_W'(w_q));
      ry <= clamp_pos(ry_raw, fh  - DIM_W'(h_q));
      cx <= clamp_pos(cx_raw, cfw - DIM_W'(cw_q));
      cy <= clamp_pos(cy_raw, cfh - DIM_W'(ch_q));
    end
    if (cmd.mult) begin
      chroma_base <= ADDR_W'(cy * cfg.chroma_stride) + ADDR_W'(cx);
    end
    if (cmd.emit) begin
      plane       <= cmd.plane;
      src_address <= addr;
      last        <= cmd.last;
      if (cmd.plane == PLANE_LUMA) begin
        row_length <= w_q;
        dest_x     <= px[POS_W-1:0];
        dest_y     <= POS_W'(py + DIM_W'(row_cnt));
      end else begin
        row_length <= cw_q;
        dest_x     <= cpx[POS_W-1:0];
        dest_y     <= POS_W'(cpy + DIM_W'(row_cnt));
      end
    end
    // The address walks the rows; U and V of one row share an address.
    if (cmd.mult) begin
      addr <= luma_base;
    end else if (cmd.emit && cmd.plane == PLANE_LUMA) begin
      if (st.luma_row_last) begin
        addr <= chroma_base;
      end else begin
        addr <= addr + ADDR_W'(cfg.luma_stride);
      end
    end else if (cmd.emit && cmd.plane == PLANE_V) begin
      addr <= addr + ADDR_W'(cfg.chroma_stride);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe  <= 1'b0;
      row_cnt <= '0;
    end else begin
      strobe <= cmd.emit;
      if (cmd.load) begin
        row_cnt <= '0;
      end else if (cmd.emit && cmd.plane == PLANE_LUMA) begin
        row_cnt <= st.luma_row_last ? '0 : row_cnt + ROW_W'(1);
      end else if (cmd.emit && cmd.plane == PLANE_V) begin
        row_cnt <= row_cnt + ROW_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/mc_reference_row_fetch_generator.sv
// Top level of the motion compensation reference row fetch generator.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ---------------------------------------------
//   request   start / busy           mb_col, mb_row, mv_dx, mv_dy
//   result    strobe (one cycle)     plane, src_address, row_length, dest_x,
//                                    dest_y, last
//   config    psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// A request is taken when start is high and busy is low. The block then works
// on geometry: checking the macroblock against the frame edges, cutting the
// block, clamping the reference position and forming the luma and chroma base
// addresses with one multiplier per plane. After that one row descriptor leaves
// per cycle: h luma rows, then, if the chroma block is not empty, U and V for
// each of ch chroma rows. busy falls in the cycle in which the final descriptor
// is presented with strobe, and the next request may start then. A macroblock
// lying beyond the frame produces no descriptor. Reset is synchronous; it
// restores the register defaults and returns the controller to idle. The
// receiver cannot stall, so each descriptor is valid for exactly the single
// cycle in which strobe is high.
`default_nettype none

module mc_reference_row_fetch_generator (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Request channel.
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [mcf_pkg::COORD_W-1:0]        mb_col,
  input  wire logic [mcf_pkg::COORD_W-1:0]        mb_row,
  input  wire logic signed [mcf_pkg::MV_W-1:0]    mv_dx,
  input  wire logic signed [mcf_pkg::MV_W-1:0]    mv_dy,
  // Descriptor channel.
  output logic                                    strobe,
  output logic [1:0]                              plane,
  output logic [mcf_pkg::ADDR_W-1:0]              src_address,
  output logic [mcf_pkg::LEN_W-1:0]               row_length,
  output logic [mcf_pkg::POS_W-1:0]               dest_x,
  output logic [mcf_pkg::POS_W-1:0]               dest_y,
  output logic                                    last,
  // Configuration port.
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mcf_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [mcf_pkg::PDATA_W-1:0]        pwdata,
  output logic      [mcf_pkg::PDATA_W-1:0]        prdata,
  output logic                                    pready
);
  import mcf_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;

  // Register bank: frame size and the two plane strides.
  mcf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller steps through the geometry phases and then the rows.
  mcf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // The datapath holds the request, the cut sizes, the clamped positions,
  // the running row address and the registered descriptor outputs.
  mcf_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .st          (st),
    .mb_col      (mb_col),
    .mb_row      (mb_row),
    .mv_dx       (mv_dx),
    .mv_dy       (mv_dy),
    .strobe      (strobe),
    .plane       (plane),
    .src_address (src_address),
    .row_length  (row_length),
    .dest_x      (dest_x),
    .dest_y      (dest_y),
    .last        (last)
  );

endmodule

`default_nettype wire

>>> design/mcf_checker.sv
// Port-level checks for the row fetch generator, bound to the top level.
`default_nettype none

module mcf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic [1:0] plane,
  input wire logic [4:0] row_length,
  input wire logic       last
);
  import mcf_pkg::*;

  // Every descriptor belongs to a request that was in progress.
  a_strobe_in_request: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("descriptor issued outside a request");

  // An accepted request occupies the block.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted without raising busy");

  // The final descriptor is never followed directly by another.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("descriptor follows the final one of a macroblock");

  // V rows immediately follow their U rows.
  a_v_after_u: assert property (@(posedge clk) disable iff (rst)
    (strobe && plane == PLANE_V) |-> ($past(strobe) && $past(plane) == PLANE_U))
    else $error("V row without the matching U row before it");

  // A row always copies between one and a full block of bytes.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (row_length != 5'd0 && row_length <= 5'(LUMA_BLOCK)))
    else $error("row length out of range");

endmodule

bind mc_reference_row_fetch_generator mcf_checker u_mcf_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .strobe     (strobe),
  .plane      (plane),
  .row_length (row_length),
  .last       (last)
);

`default_nettype wire
